// ----- rtl/core/kmle_pkg.sv -----
// ----------------------------------------------------------------------------
// kmle_pkg
// Shared constants, codes and types of the key matrix layer event engine.
// ----------------------------------------------------------------------------
package kmle_pkg;

    localparam int ROWS       = 8;
    localparam int COLS       = 16;
    localparam int LAYERS     = 4;
    localparam int KEY_SLOTS  = 6;
    localparam int KEYS       = ROWS * COLS;
    localparam int TABLE_SIZE = LAYERS * KEYS;

    localparam int KEY_W   = (KEYS > 1) ? $clog2(KEYS) : 1;
    localparam int COL_W   = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int LAT_W   = $clog2(LAYERS + 1);
    localparam int SLOT_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int FILL_W  = $clog2(KEY_SLOTS + 1);
    localparam int CNT_MAX = (KEYS > KEY_SLOTS) ? KEYS : KEY_SLOTS;
    localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

    // field widths fixed by the word format
    localparam int ADDR_W  = 9;
    localparam int KIND_W  = 3;
    localparam int CODE_W  = 8;
    localparam int TGT_W   = 2;
    localparam int ROW_W   = 3;
    localparam int BITS_W  = 16;
    localparam int CNTR_W  = 8;
    localparam int DFLT_W  = 2;
    localparam int ENTRY_W = KIND_W + CODE_W + TGT_W;
    localparam int CIDX_W  = 2;

    localparam logic [CNTR_W-1:0] PRESS_LEVEL  = 8'd2;
    localparam logic [CNTR_W-1:0] CEIL_RESET   = 8'd5;
    localparam logic [LAT_W-1:0]  NO_LAYER     = LAT_W'(LAYERS);

    localparam logic [KIND_W-1:0] KIND_NORMAL    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_MOMENTARY = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TOGGLE    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TO        = 3'd3;
    localparam logic [KIND_W-1:0] KIND_LOWER     = 3'd4;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CIDX_W-1:0] CFG_CEILING = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_DEFAULT = 2'd1;

    localparam logic [3:0] OP_NONE    = 4'd0;
    localparam logic [3:0] OP_CLEAR   = 4'd1;
    localparam logic [3:0] OP_LOAD    = 4'd2;
    localparam logic [3:0] OP_ROW_RD  = 4'd3;
    localparam logic [3:0] OP_ROW_WR  = 4'd4;
    localparam logic [3:0] OP_WALK_RD = 4'd5;
    localparam logic [3:0] OP_WALK_WR = 4'd6;
    localparam logic [3:0] OP_SLOT_RD = 4'd7;
    localparam logic [3:0] OP_SLOT_EX = 4'd8;
    localparam logic [3:0] OP_FLUSH   = 4'd9;

    localparam logic [1:0] PH_MOMENTARY = 2'd0;
    localparam logic [1:0] PH_ACTIONS   = 2'd1;
    localparam logic [1:0] PH_RELEASE   = 2'd2;
    localparam logic [1:0] PH_PRESS     = 2'd3;

    typedef struct packed {
        logic [3:0]       op;
        logic [1:0]       phase;
        logic [CNT_W-1:0] index;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_sample;
        logic row_ok;
        logic scan_done;
        logic ex_wait;
        logic flush_wait;
    } dp_status_t;

endpackage

// ----- rtl/core/kmle_req_if.sv -----
// ----------------------------------------------------------------------------
// kmle_req_if
// Request channel: keymap writes and row samples.
// ----------------------------------------------------------------------------
interface kmle_req_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [8:0]  entry_address;
    logic [2:0]  entry_kind;
    logic [7:0]  entry_keycode;
    logic [1:0]  entry_layer;
    logic [2:0]  row_index;
    logic [15:0] column_bits;
    logic        scan_done;

    modport source (output valid, command, entry_address, entry_kind, entry_keycode,
                    entry_layer, row_index, column_bits, scan_done, input ready);
    modport sink (input valid, command, entry_address, entry_kind, entry_keycode,
                  entry_layer, row_index, column_bits, scan_done, output ready);
endinterface

// ----- rtl/core/kmle_evt_if.sv -----
// ----------------------------------------------------------------------------
// kmle_evt_if
// Event channel: key press and release words.
// ----------------------------------------------------------------------------
interface kmle_evt_if;
    logic       valid;
    logic       ready;
    logic [7:0] keycode;
    logic       is_press;
    logic       last;

    modport source (output valid, keycode, is_press, last, input ready);
    modport sink (input valid, keycode, is_press, last, output ready);
endinterface

// ----- rtl/core/kmle_cfg_if.sv -----
// ----------------------------------------------------------------------------
// kmle_cfg_if
// Configuration write channel.
// ----------------------------------------------------------------------------
interface kmle_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/kmle_ctrl.sv -----
// ----------------------------------------------------------------------------
// kmle_ctrl
// Sequencer: clearing pass, row update, key walk, slot phases and flush.
// ----------------------------------------------------------------------------
module kmle_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  kmle_pkg::dp_status_t status,
    output kmle_pkg::ctrl_cmd_t  cmd
);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_DECODE  = 4'd2;
    localparam logic [3:0] ST_ROW_RD  = 4'd3;
    localparam logic [3:0] ST_ROW_WR  = 4'd4;
    localparam logic [3:0] ST_WALK_RD = 4'd5;
    localparam logic [3:0] ST_WALK_WR = 4'd6;
    localparam logic [3:0] ST_SLOT_RD = 4'd7;
    localparam logic [3:0] ST_SLOT_EX = 4'd8;
    localparam logic [3:0] ST_FLUSH   = 4'd9;

    logic [3:0]                 state_reg, state_next;
    logic [kmle_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [1:0]                 phase_reg, phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            phase_reg <= kmle_pkg::PH_MOMENTARY;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        cmd.op     = kmle_pkg::OP_NONE;
        cmd.phase  = phase_reg;
        cmd.index  = cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = kmle_pkg::OP_CLEAR;
                if (32'(cnt_reg) == kmle_pkg::KEYS - 1)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = kmle_pkg::OP_LOAD;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cnt_next = '0;
                priority if (!status.is_sample)
                    state_next = ST_IDLE;
                else if (status.row_ok)
                    state_next = ST_ROW_RD;
                else if (status.scan_done)
                    state_next = ST_WALK_RD;
                else
                    state_next = ST_IDLE;
            end
            ST_ROW_RD:
            begin
                cmd.op     = kmle_pkg::OP_ROW_RD;
                state_next = ST_ROW_WR;
            end
            ST_ROW_WR:
            begin
                cmd.op = kmle_pkg::OP_ROW_WR;
                if (32'(cnt_reg) == kmle_pkg::COLS - 1)
                begin
                    cnt_next   = '0;
                    state_next = status.scan_done ? ST_WALK_RD : ST_IDLE;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_ROW_RD;
                end
            end
            ST_WALK_RD:
            begin
                cmd.op     = kmle_pkg::OP_WALK_RD;
                state_next = ST_WALK_WR;
            end
            ST_WALK_WR:
            begin
                cmd.op = kmle_pkg::OP_WALK_WR;
                if (32'(cnt_reg) == kmle_pkg::KEYS - 1)
                begin
                    cnt_next   = '0;
                    phase_next = kmle_pkg::PH_MOMENTARY;
                    state_next = ST_SLOT_RD;
                end
                else
                begin
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = ST_WALK_RD;
                end
            end
            ST_SLOT_RD:
            begin
                cmd.op     = kmle_pkg::OP_SLOT_RD;
                state_next = ST_SLOT_EX;
            end
            ST_SLOT_EX:
            begin
                cmd.op = kmle_pkg::OP_SLOT_EX;
                if (!status.ex_wait)
                begin
                    if (32'(cnt_reg) == kmle_pkg::KEY_SLOTS - 1)
                    begin
                        cnt_next = '0;
                        if (phase_reg == kmle_pkg::PH_PRESS)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            phase_next = phase_reg + 1'b1;
                            state_next = ST_SLOT_RD;
                        end
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_SLOT_RD;
                    end
                end
            end
            ST_FLUSH:
            begin
                cmd.op = kmle_pkg::OP_FLUSH;
                if (!status.flush_wait)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/kmle_datapath.sv -----
// ----------------------------------------------------------------------------
// kmle_datapath
// Debounce, latch and keymap memories, slot lists, layer bits and event output.
// ----------------------------------------------------------------------------
module kmle_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  kmle_pkg::ctrl_cmd_t  cmd,
    output kmle_pkg::dp_status_t status,
    input  logic                 command,
    input  logic [8:0]           entry_address,
    input  logic [2:0]           entry_kind,
    input  logic [7:0]           entry_keycode,
    input  logic [1:0]           entry_layer,
    input  logic [2:0]           row_index,
    input  logic [15:0]          column_bits,
    input  logic                 scan_done,
    input  logic                 cfg_valid,
    input  logic [1:0]           cfg_index,
    input  logic [7:0]           cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_keycode,
    output logic                 out_is_press,
    output logic                 out_last
);

    localparam int KW = kmle_pkg::KEY_W;
    localparam int AW = kmle_pkg::ADDR_W;
    localparam int LW = kmle_pkg::LAT_W;
    localparam int NS = kmle_pkg::KEY_SLOTS;
    localparam int NL = kmle_pkg::LAYERS;
    localparam int SLOT_SEL_W = kmle_pkg::SLOT_W;

    logic [kmle_pkg::CNTR_W-1:0]  dbc_mem [kmle_pkg::KEYS];
    logic [LW-1:0]                lat_mem [kmle_pkg::KEYS];
    logic [kmle_pkg::ENTRY_W-1:0] kmap_mem [kmle_pkg::TABLE_SIZE];

    logic [kmle_pkg::CNTR_W-1:0]  dbc_q;
    logic [LW-1:0]                lat_q;
    logic [kmle_pkg::ENTRY_W-1:0] kmap_q;

    logic [kmle_pkg::CNTR_W-1:0] ceil_reg;
    logic [kmle_pkg::DFLT_W-1:0] dflt_reg;

    logic                        is_sample_reg;
    logic                        scan_done_reg;
    logic [kmle_pkg::ROW_W-1:0]  row_reg;
    logic [kmle_pkg::BITS_W-1:0] bits_reg;

    logic [NS-1:0]      prs_vld_reg;
    logic [AW-1:0]      prs_idx_reg [NS];
    logic [NS-1:0]      prv_vld_reg;
    logic [AW-1:0]      prv_idx_reg [NS];
    logic [kmle_pkg::FILL_W-1:0] fill_reg;

    logic [NL-1:0] layer_reg, layer_next;

    logic                 pend_vld_reg;
    logic [7:0]           pend_code_reg;
    logic                 pend_press_reg;

    logic                 out_vld_reg;
    logic [7:0]           out_code_reg;
    logic                 out_press_reg;
    logic                 out_last_reg;

    logic [KW-1:0]              key_idx;
    logic [kmle_pkg::COL_W-1:0] col_idx;
    logic [KW-1:0]              row_key;
    logic                       closed;
    logic [kmle_pkg::CNTR_W:0]  inc_sum;
    logic [kmle_pkg::CNTR_W-1:0] dbc_new;
    logic [LW-1:0]              act_layer;
    logic [LW-1:0]              lat_new;
    logic                       key_down;

    logic [SLOT_SEL_W-1:0]      slot_sel;
    logic                       slot_vld;
    logic [AW-1:0]              slot_idx;
    logic                       in_prs;
    logic                       in_prv;
    logic [kmle_pkg::KIND_W-1:0] kind;
    logic [kmle_pkg::TGT_W-1:0]  tgt;
    logic                       tgt_ok;
    logic                       layer_act;
    logic                       evt_found;
    logic                       evt_press;
    logic                       out_busy;
    logic                       ex_step;
    logic                       flush_step;
    logic                       push_out;

    assign key_idx = cmd.index[KW-1:0];
    assign col_idx = cmd.index[kmle_pkg::COL_W-1:0];
    assign row_key = KW'(int'(row_reg) * kmle_pkg::COLS + int'(col_idx));
    assign closed  = (32'(col_idx) < 32'd16) && (({16'b0, bits_reg} >> col_idx) & 32'd1) != 0;
    assign inc_sum = {1'b0, dbc_q} + 9'd1;

    always_comb
    begin
        if (closed)
            dbc_new = (inc_sum > {1'b0, ceil_reg}) ? ceil_reg : inc_sum[kmle_pkg::CNTR_W-1:0];
        else
            dbc_new = (dbc_q == '0) ? '0 : dbc_q - 1'b1;
    end

    // highest set layer bit wins, else the default layer
    always_comb
    begin
        act_layer = (32'(dflt_reg) < NL) ? LW'(dflt_reg) : LW'(NL - 1);
        for (int j = 0; j < NL; j++)
        begin
            if (layer_reg[j])
                act_layer = LW'(j);
        end
    end

    assign key_down = dbc_q > kmle_pkg::PRESS_LEVEL;
    assign lat_new  = (lat_q >= kmle_pkg::NO_LAYER) ? act_layer : lat_q;

    // memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == kmle_pkg::OP_CLEAR)
            dbc_mem[key_idx] <= '0;
        else if (cmd.op == kmle_pkg::OP_ROW_WR)
            dbc_mem[row_key] <= dbc_new;
        if (cmd.op == kmle_pkg::OP_ROW_RD)
            dbc_q <= dbc_mem[row_key];
        else if (cmd.op == kmle_pkg::OP_WALK_RD)
            dbc_q <= dbc_mem[key_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == kmle_pkg::OP_CLEAR)
            lat_mem[key_idx] <= kmle_pkg::NO_LAYER;
        else if (cmd.op == kmle_pkg::OP_WALK_WR)
            lat_mem[key_idx] <= key_down ? lat_new : kmle_pkg::NO_LAYER;
        if (cmd.op == kmle_pkg::OP_WALK_RD)
            lat_q <= lat_mem[key_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == kmle_pkg::OP_LOAD && command == kmle_pkg::CMD_WRITE
            && 32'(entry_address) < kmle_pkg::TABLE_SIZE)
            kmap_mem[entry_address] <= {entry_kind, entry_keycode, entry_layer};
        if (cmd.op == kmle_pkg::OP_SLOT_RD)
            kmap_q <= kmap_mem[slot_idx];
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ceil_reg <= kmle_pkg::CEIL_RESET;
            dflt_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == kmle_pkg::CFG_CEILING)
                ceil_reg <= cfg_data;
            else if (cfg_index == kmle_pkg::CFG_DEFAULT)
                dflt_reg <= cfg_data[kmle_pkg::DFLT_W-1:0];
        end
    end

    // captured request word
    always_ff @(posedge clk)
    begin
        if (cmd.op == kmle_pkg::OP_LOAD)
        begin
            is_sample_reg <= (command == kmle_pkg::CMD_SAMPLE);
            scan_done_reg <= scan_done;
            row_reg       <= row_index;
            bits_reg      <= column_bits;
        end
    end

    // slot under test and membership searches
    assign slot_sel = cmd.index[SLOT_SEL_W-1:0];

    always_comb
    begin
        if (cmd.phase == kmle_pkg::PH_MOMENTARY || cmd.phase == kmle_pkg::PH_RELEASE)
        begin
            slot_vld = prv_vld_reg[slot_sel];
            slot_idx = prv_idx_reg[slot_sel];
        end
        else
        begin
            slot_vld = prs_vld_reg[slot_sel];
            slot_idx = prs_idx_reg[slot_sel];
        end
    end

    always_comb
    begin
        in_prs = 1'b0;
        in_prv = 1'b0;
        for (int i = 0; i < NS; i++)
        begin
            if (prs_vld_reg[i] && prs_idx_reg[i] == slot_idx)
                in_prs = 1'b1;
            if (prv_vld_reg[i] && prv_idx_reg[i] == slot_idx)
                in_prv = 1'b1;
        end
    end

    assign kind      = kmap_q[kmle_pkg::ENTRY_W-1 -: kmle_pkg::KIND_W];
    assign tgt       = kmap_q[kmle_pkg::TGT_W-1:0];
    assign tgt_ok    = 32'(tgt) < NL;
    assign layer_act = (kind >= kmle_pkg::KIND_MOMENTARY) && (kind <= kmle_pkg::KIND_LOWER);

    always_comb
    begin
        evt_found = 1'b0;
        evt_press = 1'b0;
        if (cmd.phase == kmle_pkg::PH_RELEASE)
            evt_found = slot_vld && !layer_act && !in_prs;
        else if (cmd.phase == kmle_pkg::PH_PRESS)
        begin
            evt_found = slot_vld && !layer_act && !in_prv;
            evt_press = 1'b1;
        end
    end

    assign out_busy   = out_vld_reg && !out_ready;
    assign ex_step    = (cmd.op == kmle_pkg::OP_SLOT_EX) && !(evt_found && pend_vld_reg && out_busy);
    assign flush_step = (cmd.op == kmle_pkg::OP_FLUSH) && !(pend_vld_reg && out_busy);
    assign push_out   = pend_vld_reg && ((ex_step && evt_found) || flush_step);

    // layer actions
    always_comb
    begin
        layer_next = layer_reg;
        if (cmd.op == kmle_pkg::OP_SLOT_EX && slot_vld && tgt_ok)
        begin
            if (cmd.phase == kmle_pkg::PH_MOMENTARY)
            begin
                if (kind == kmle_pkg::KIND_MOMENTARY && !in_prs)
                    for (int j = 0; j < NL; j++)
                        if (32'(tgt) == j)
                            layer_next[j] = 1'b0;
            end
            else if (cmd.phase == kmle_pkg::PH_ACTIONS && layer_act && !in_prv)
            begin
                for (int j = 0; j < NL; j++)
                begin
                    unique case (kind)
                        kmle_pkg::KIND_MOMENTARY:
                            if (32'(tgt) == j) layer_next[j] = 1'b1;
                        kmle_pkg::KIND_TOGGLE:
                            if (32'(tgt) == j) layer_next[j] = !layer_reg[j];
                        kmle_pkg::KIND_TO:
                            if (32'(tgt) == j) layer_next[j] = 1'b1;
                            else if (j > 32'(tgt)) layer_next[j] = 1'b0;
                        kmle_pkg::KIND_LOWER:
                            if (act_layer != '0 && 32'(act_layer) == j) layer_next[j] = 1'b0;
                        default:
                            layer_next[j] = layer_reg[j];
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            layer_reg <= '0;
        else
            layer_reg <= layer_next;
    end

    // slot lists
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prs_vld_reg <= '0;
            prv_vld_reg <= '0;
            fill_reg    <= '0;
        end
        else if (cmd.op == kmle_pkg::OP_LOAD)
        begin
            prs_vld_reg <= '0;
            fill_reg    <= '0;
        end
        else if (cmd.op == kmle_pkg::OP_WALK_WR && key_down && 32'(fill_reg) < NS)
        begin
            prs_vld_reg[fill_reg[SLOT_SEL_W-1:0]] <= 1'b1;
            fill_reg <= fill_reg + 1'b1;
        end
        else if (flush_step)
        begin
            prv_vld_reg <= prs_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == kmle_pkg::OP_WALK_WR && key_down && 32'(fill_reg) < NS)
            prs_idx_reg[fill_reg[SLOT_SEL_W-1:0]] <=
                AW'(int'(lat_new) * kmle_pkg::KEYS + int'(key_idx));
        if (flush_step)
            for (int i = 0; i < NS; i++)
                prv_idx_reg[i] <= prs_idx_reg[i];
    end

    // one event held back so that the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (push_out)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
            if (ex_step && evt_found)
                pend_vld_reg <= 1'b1;
            else if (flush_step)
                pend_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ex_step && evt_found)
        begin
            pend_code_reg  <= kmap_q[kmle_pkg::TGT_W +: kmle_pkg::CODE_W];
            pend_press_reg <= evt_press;
            if (pend_vld_reg)
            begin
                out_code_reg  <= pend_code_reg;
                out_press_reg <= pend_press_reg;
                out_last_reg  <= 1'b0;
            end
        end
        else if (flush_step && pend_vld_reg)
        begin
            out_code_reg  <= pend_code_reg;
            out_press_reg <= pend_press_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign out_valid    = out_vld_reg;
    assign out_keycode  = out_code_reg;
    assign out_is_press = out_press_reg;
    assign out_last     = out_last_reg;

    assign status.is_sample  = is_sample_reg;
    assign status.row_ok     = 32'(row_reg) < kmle_pkg::ROWS;
    assign status.scan_done  = scan_done_reg;
    assign status.ex_wait    = (cmd.op == kmle_pkg::OP_SLOT_EX) && !ex_step;
    assign status.flush_wait = (cmd.op == kmle_pkg::OP_FLUSH) && !flush_step;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= NS)
        else $error("pressed list fill count beyond slot count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (ex_step && evt_found && pend_vld_reg) |-> !out_busy)
        else $error("event pushed over a stalled word");

    a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
        flush_step |=> !pend_vld_reg)
        else $error("held event survived the flush");

    a_last_at_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (flush_step && pend_vld_reg) |=> (out_vld_reg && out_last_reg))
        else $error("final event not marked last");
`endif

endmodule

// ----- rtl/core/key_matrix_layer_event_engine.sv -----
// ----------------------------------------------------------------------------
// key_matrix_layer_event_engine
// Debounced key matrix scanner with layered keymap and press/release events.
// ----------------------------------------------------------------------------
// req: one word per keymap write (command 0) or per row sample (command 1).
//   A row sample runs the debounce read-modify-write over the row's keys
//   (one memory port). With scan_done set, the end-of-scan evaluation adds
//   the key walk over all ROWS*COLS keys, the four slot passes over the
//   keymap memory and a flush.
//   One word is worked on at a time; req.ready is high only between words.
// evt: release words first, then press words, the final one with last set.
//   A stalled receiver holds the output register; the engine waits on the
//   next event until the word ahead is taken.
// cfg: index 0 debounce ceiling, 1 default layer; always ready. The user must
//   write it only while the engine is between words; the block itself does not enforce it.
// reset: a clearing pass over the ROWS*COLS keys zeroes the debounce
//   counters and sets the latched layers to none; req.ready stays low until
//   it ends. The keymap is undefined until written.
// ----------------------------------------------------------------------------
module key_matrix_layer_event_engine
(
    input logic          clk,
    input logic          rst_n,
    kmle_req_if.sink     req,
    kmle_evt_if.source   evt,
    kmle_cfg_if.sink     cfg
);

    kmle_pkg::ctrl_cmd_t  cmd;
    kmle_pkg::dp_status_t status;

    assign cfg.ready = 1'b1;

    kmle_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .status    (status),
        .cmd       (cmd)
    );

    kmle_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .command       (req.command),
        .entry_address (req.entry_address),
        .entry_kind    (req.entry_kind),
        .entry_keycode (req.entry_keycode),
        .entry_layer   (req.entry_layer),
        .row_index     (req.row_index),
        .column_bits   (req.column_bits),
        .scan_done     (req.scan_done),
        .cfg_valid     (cfg.valid),
        .cfg_index     (cfg.index),
        .cfg_data      (cfg.data),
        .out_valid     (evt.valid),
        .out_ready     (evt.ready),
        .out_keycode   (evt.keycode),
        .out_is_press  (evt.is_press),
        .out_last      (evt.last)
    );

endmodule

// ----- bench/tb_key_matrix_layer_event_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_matrix_layer_event_engine
// Loads the keymap, runs directed and random matrix scans under several
// ceiling and default-layer settings, and checks every press/release word
// against a cycle-free predictor of debounce, layers and the pressed list.
// ----------------------------------------------------------------------------
module tb_key_matrix_layer_event_engine;

    localparam int ADDR_W     = kmle_pkg::ADDR_W;
    localparam int KIND_W     = kmle_pkg::KIND_W;
    localparam int CODE_W     = kmle_pkg::CODE_W;
    localparam int TGT_W      = kmle_pkg::TGT_W;
    localparam int ROW_W      = kmle_pkg::ROW_W;
    localparam int BITS_W     = kmle_pkg::BITS_W;
    localparam int CNTR_W     = kmle_pkg::CNTR_W;
    localparam int DFLT_W     = kmle_pkg::DFLT_W;
    localparam int ENTRY_W    = kmle_pkg::ENTRY_W;
    localparam int ROWS       = kmle_pkg::ROWS;
    localparam int COLS       = kmle_pkg::COLS;
    localparam int LAYERS     = kmle_pkg::LAYERS;
    localparam int KEY_SLOTS  = kmle_pkg::KEY_SLOTS;
    localparam int KEYS       = kmle_pkg::KEYS;
    localparam int TABLE_SIZE = kmle_pkg::TABLE_SIZE;

    localparam logic [CNTR_W-1:0] PRESS_LEVEL    = kmle_pkg::PRESS_LEVEL;
    localparam logic [CNTR_W-1:0] CEIL_RESET     = kmle_pkg::CEIL_RESET;
    localparam logic [KIND_W-1:0] KIND_NORMAL    = kmle_pkg::KIND_NORMAL;
    localparam logic [KIND_W-1:0] KIND_MOMENTARY = kmle_pkg::KIND_MOMENTARY;
    localparam logic [KIND_W-1:0] KIND_TOGGLE    = kmle_pkg::KIND_TOGGLE;
    localparam logic [KIND_W-1:0] KIND_TO        = kmle_pkg::KIND_TO;
    localparam logic [KIND_W-1:0] KIND_LOWER     = kmle_pkg::KIND_LOWER;
    localparam logic              CMD_WRITE      = kmle_pkg::CMD_WRITE;
    localparam logic              CMD_SAMPLE     = kmle_pkg::CMD_SAMPLE;
    localparam logic [1:0]        CFG_CEILING    = kmle_pkg::CFG_CEILING;
    localparam logic [1:0]        CFG_DEFAULT    = kmle_pkg::CFG_DEFAULT;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE      = 400;
    // the random scans close contacts only in these rows, so only their entries are loaded
    localparam int LIVE_ROWS   = 4;

    typedef struct {
        logic              command;
        logic [ADDR_W-1:0] address;
        logic [KIND_W-1:0] kind;
        logic [CODE_W-1:0] code;
        logic [TGT_W-1:0]  layer;
        logic [ROW_W-1:0]  row;
        logic [BITS_W-1:0] bits;
        logic              done;
    } req_word_t;

    typedef struct {
        logic [7:0] keycode;
        logic       is_press;
        logic       last;
    } key_event_t;

    logic clk;
    logic rst_n;
    int   cycles;
    int   fails;
    bit   sender_gaps;
    bit   receiver_stalls;
    int   stall_left;

    kmle_req_if req_if();
    kmle_evt_if evt_if();
    kmle_cfg_if cfg_if();

    key_matrix_layer_event_engine u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .evt   (evt_if),
        .cfg   (cfg_if)
    );

    // predictor state
    logic [CNTR_W-1:0]  ceiling;
    logic [DFLT_W-1:0]  base_layer;
    logic [CNTR_W-1:0]  key_level [KEYS];
    int unsigned        key_layer [KEYS];
    bit                 layer_on [LAYERS];
    bit                 now_valid [KEY_SLOTS];
    int unsigned        now_key [KEY_SLOTS];
    bit                 prev_valid [KEY_SLOTS];
    int unsigned        prev_key [KEY_SLOTS];
    logic [ENTRY_W-1:0] keymap_word [TABLE_SIZE];
    logic [15:0]        row_pattern [ROWS];
    key_event_t         pending_events[$];

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("key_matrix_layer_event_engine test failed");
            $finish;
        end
    end

    function automatic int gap_length(int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, long_max);
    endfunction

    function automatic logic [KIND_W-1:0] kind_at(int unsigned idx);
        return keymap_word[idx][ENTRY_W-1 -: KIND_W];
    endfunction

    function automatic logic [TGT_W-1:0] target_at(int unsigned idx);
        return keymap_word[idx][TGT_W-1:0];
    endfunction

    function automatic bit is_action(int unsigned idx);
        return kind_at(idx) >= KIND_MOMENTARY && kind_at(idx) <= KIND_LOWER;
    endfunction

    function automatic int unsigned top_layer();
        for (int i = LAYERS - 1; i >= 0; i--)
            if (layer_on[i])
                return i;
        return (base_layer < LAYERS) ? base_layer : LAYERS - 1;
    endfunction

    function automatic bit held(bit in_prev, int unsigned idx);
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            if (in_prev && prev_valid[i] && prev_key[i] == idx)
                return 1'b1;
            if (!in_prev && now_valid[i] && now_key[i] == idx)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic run_layer_action(int unsigned idx);
        int unsigned t;
        t = target_at(idx);
        case (kind_at(idx))
            KIND_MOMENTARY: layer_on[t] = 1'b1;
            KIND_TOGGLE:    layer_on[t] = !layer_on[t];
            KIND_TO:
            begin
                for (int j = t + 1; j < LAYERS; j++)
                    layer_on[j] = 1'b0;
                layer_on[t] = 1'b1;
            end
            KIND_LOWER:
                if (top_layer() > 0)
                    layer_on[top_layer()] = 1'b0;
            default: ;
        endcase
    endtask

    task automatic scan_events();
        int unsigned layer;
        int          fill;
        key_event_t  ev;
        key_event_t  batch[$];
        layer = top_layer();
        fill  = 0;
        for (int k = 0; k < KEYS; k++)
        begin
            if (key_level[k] > PRESS_LEVEL)
            begin
                if (key_layer[k] >= LAYERS)
                    key_layer[k] = layer;
                if (fill < KEY_SLOTS)
                begin
                    now_valid[fill] = 1'b1;
                    now_key[fill]   = key_layer[k] * KEYS + k;
                    fill++;
                end
            end
            else
                key_layer[k] = LAYERS;
        end
        for (int i = fill; i < KEY_SLOTS; i++)
        begin
            now_valid[i] = 1'b0;
            now_key[i]   = 0;
        end
        // momentary layers drop when their key goes up
        for (int i = 0; i < KEY_SLOTS; i++)
            if (prev_valid[i] && kind_at(prev_key[i]) == KIND_MOMENTARY
                && !held(1'b0, prev_key[i]))
                layer_on[target_at(prev_key[i])] = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
            if (now_valid[i] && is_action(now_key[i]) && !held(1'b1, now_key[i]))
                run_layer_action(now_key[i]);
        for (int i = 0; i < KEY_SLOTS; i++)
            if (prev_valid[i] && !is_action(prev_key[i]) && !held(1'b0, prev_key[i]))
            begin
                ev.keycode  = keymap_word[prev_key[i]][9:2];
                ev.is_press = 1'b0;
                ev.last     = 1'b0;
                batch.push_back(ev);
            end
        for (int i = 0; i < KEY_SLOTS; i++)
            if (now_valid[i] && !is_action(now_key[i]) && !held(1'b1, now_key[i]))
            begin
                ev.keycode  = keymap_word[now_key[i]][9:2];
                ev.is_press = 1'b1;
                ev.last     = 1'b0;
                batch.push_back(ev);
            end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            pending_events.push_back(batch[i]);
        prev_valid = now_valid;
        prev_key   = now_key;
    endtask

    task automatic predict_word(req_word_t w);
        int k;
        if (w.command == CMD_WRITE)
            keymap_word[w.address] = {w.kind, w.code, w.layer};
        else
        begin
            for (int c = 0; c < COLS; c++)
            begin
                k = w.row * COLS + c;
                if (w.bits[c])
                    key_level[k] = (key_level[k] + 9'd1 > ceiling) ? ceiling
                                                                  : key_level[k] + 8'd1;
                else if (key_level[k] > 0)
                    key_level[k] = key_level[k] - 8'd1;
            end
            if (w.done)
                scan_events();
        end
    endtask

    task automatic send_word(req_word_t w);
        int gap;
        gap = sender_gaps ? gap_length(60) : 0;
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid         <= 1'b1;
        req_if.command       <= w.command;
        req_if.entry_address <= w.address;
        req_if.entry_kind    <= w.kind;
        req_if.entry_keycode <= w.code;
        req_if.entry_layer   <= w.layer;
        req_if.row_index     <= w.row;
        req_if.column_bits   <= w.bits;
        req_if.scan_done     <= w.done;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        predict_word(w);
    endtask

    task automatic write_entry(int unsigned addr, logic [2:0] kind, logic [7:0] code,
                               logic [1:0] layer);
        req_word_t w;
        w = '{CMD_WRITE, addr, kind, code, layer, $urandom, $urandom, $urandom};
        send_word(w);
    endtask

    task automatic send_row(int unsigned row, logic [15:0] bits, bit done);
        req_word_t w;
        w = '{CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom, row, bits, done};
        send_word(w);
    endtask

    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (pending_events.size() > 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_register(logic [1:0] index, logic [7:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        if (index == CFG_CEILING)
            ceiling = data;
        else if (index == CFG_DEFAULT)
            base_layer = data[1:0];
    endtask

    function automatic logic [2:0] random_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return KIND_NORMAL;
        else if (r < 94)
            return $urandom_range(KIND_MOMENTARY, KIND_LOWER);
        return $urandom_range(5, 7);
    endfunction

    function automatic logic [15:0] random_pattern();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 16'h0000;
        else if (r < 85)
            return (16'h1 << $urandom_range(0, 15)) | (16'h1 << $urandom_range(0, 15));
        return $urandom;
    endfunction

    // one full matrix scan; now and then a short or shuffled scan, or a keymap rewrite
    task automatic random_scan();
        int rows;
        int row;
        for (int r = 0; r < LIVE_ROWS; r++)
            if ($urandom_range(0, 3) == 0)
                row_pattern[r] = random_pattern();
        if ($urandom_range(0, 19) == 0)
            write_entry($urandom_range(0, TABLE_SIZE - 1), random_kind(), $urandom,
                        $urandom);
        if ($urandom_range(0, 9) == 0)
        begin
            rows = $urandom_range(1, ROWS);
            for (int r = 0; r < rows; r++)
            begin
                row = $urandom_range(0, ROWS - 1);
                send_row(row, (row < LIVE_ROWS) ? random_pattern() : 16'h0000,
                         r == rows - 1);
            end
        end
        else
            for (int r = 0; r < ROWS; r++)
                send_row(r, row_pattern[r], r == ROWS - 1);
    endtask

    // every entry of the live rows is written, in all layers, before any key is pressed
    task automatic test_keymap_load();
        for (int a = 0; a < TABLE_SIZE; a++)
            if ((a % KEYS) < LIVE_ROWS * COLS)
                write_entry(a, (a < 8) ? a[2:0] : random_kind(),
                            (a == 1) ? 8'hFF : (a == 2) ? 8'h00 : $urandom, a[1:0]);
    endtask

    task automatic test_directed();
        write_entry(2 * COLS + 0, KIND_MOMENTARY, 8'h00, 2'd1);
        write_entry(2 * COLS + 1, KIND_TOGGLE, 8'h00, 2'd2);
        write_entry(2 * COLS + 2, KIND_TO, 8'h00, 2'd3);
        write_entry(2 * COLS + 3, KIND_LOWER, 8'h00, 2'd0);
        write_entry(2 * COLS + 4, 3'd7, 8'hFF, 2'd3);
        // layer keys and an odd-kind key together
        repeat (3) send_row(2, 16'h001F, 1'b1);
        repeat (3) send_row(2, 16'h0000, 1'b1);
        // a full row overflows the pressed list
        repeat (3) send_row(0, 16'hFFFF, 1'b1);
        send_row(7, 16'h8001, 1'b0);
        repeat (3) send_row(0, 16'h0000, 1'b1);
        send_row(7, 16'h0000, 1'b1);
        wait_idle();
    endtask

    task automatic test_settings();
        logic [7:0] ceilings [6] = '{8'd3, 8'd255, 8'd1, 8'd4, 8'd200, 8'd5};
        for (int s = 0; s < 6; s++)
        begin
            write_register(CFG_CEILING, ceilings[s]);
            write_register(CFG_DEFAULT, s[1:0]);
            if (s == 2)
            begin
                // unknown register indexes are ignored
                write_register(2'd2, $urandom);
                write_register(2'd3, $urandom);
            end
            repeat (2) random_scan();
            wait_idle();
        end
    endtask

    task automatic test_random_scans();
        for (int n = 0; n < 16; n++)
        begin
            sender_gaps     = (n % 10) < 7;
            receiver_stalls = (n % 13) < 9;
            random_scan();
            // the sender holds off now and then until every word is back
            if (n % 15 == 14)
                wait_idle();
        end
        sender_gaps     = 1'b1;
        receiver_stalls = 1'b1;
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        key_event_t want;
        if (receiver_stalls && stall_left == 0 && evt_if.ready && $urandom_range(0, 5) == 0)
            stall_left <= gap_length(40);
        else if (stall_left > 0)
            stall_left <= stall_left - 1;
        evt_if.ready <= rst_n && (stall_left <= 1);
        if (evt_if.valid && evt_if.ready)
        begin
            if (pending_events.size() == 0)
            begin
                $error("unexpected event word: keycode %0h is_press %0b",
                       evt_if.keycode, evt_if.is_press);
                fails++;
            end
            else
            begin
                want = pending_events.pop_front();
                if (evt_if.keycode !== want.keycode)
                begin
                    $error("keycode: expected %0h, got %0h", want.keycode, evt_if.keycode);
                    fails++;
                end
                if (evt_if.is_press !== want.is_press)
                begin
                    $error("is_press: expected %0b, got %0b", want.is_press,
                           evt_if.is_press);
                    fails++;
                end
                if (evt_if.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, evt_if.last);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        cycles               = 0;
        fails                = 0;
        stall_left           = 0;
        sender_gaps          = 1'b1;
        receiver_stalls      = 1'b1;
        rst_n                <= 1'b0;
        req_if.valid         <= 1'b0;
        req_if.command       <= CMD_WRITE;
        req_if.entry_address <= '0;
        req_if.entry_kind    <= '0;
        req_if.entry_keycode <= '0;
        req_if.entry_layer   <= '0;
        req_if.row_index     <= '0;
        req_if.column_bits   <= '0;
        req_if.scan_done     <= 1'b0;
        cfg_if.valid         <= 1'b0;
        cfg_if.index         <= '0;
        cfg_if.data          <= '0;
        ceiling    = CEIL_RESET;
        base_layer = '0;
        for (int k = 0; k < KEYS; k++)
        begin
            key_level[k] = '0;
            key_layer[k] = LAYERS;
        end
        for (int i = 0; i < LAYERS; i++)
            layer_on[i] = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++)
        begin
            now_valid[i]  = 1'b0;
            now_key[i]    = 0;
            prev_valid[i] = 1'b0;
            prev_key[i]   = 0;
        end
        for (int r = 0; r < ROWS; r++)
            row_pattern[r] = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_keymap_load();
        test_directed();
        test_settings();
        test_random_scans();

        if (fails == 0 && pending_events.size() == 0)
            $display("key_matrix_layer_event_engine test passed");
        else
            $display("key_matrix_layer_event_engine test failed");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/kmle_pkg.sv
rtl/core/kmle_req_if.sv
rtl/core/kmle_evt_if.sv
rtl/core/kmle_cfg_if.sv
rtl/core/kmle_ctrl.sv
rtl/core/kmle_datapath.sv
rtl/core/key_matrix_layer_event_engine.sv
bench/tb_key_matrix_layer_event_engine.sv
